// File: design/ing_pkg.sv
// Shared types, codes and defaults for the impulse noise gate.
// Depends on nothing; every other design file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ing_pkg;

  localparam int WINDOW_DEFAULT = 16;

  localparam int POS_W  = 40;
  localparam int PEAK_W = 16;
  localparam int KIND_W = 2;
  localparam int REFR_W = 24;
  localparam int AMPK_W = 16;
  localparam int MINC_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W = PEAK_W + AMPK_W;

  localparam logic [REFR_W-1:0] REFR_RESET = 24'd2560;
  localparam logic [AMPK_W-1:0] AMPK_RESET = 16'd768;
  localparam logic [MINC_W-1:0] MINC_RESET = 5'd8;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_K      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT  = 2'd2;

  // Event kind codes.
  localparam logic [KIND_W-1:0] KIND_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_C = 2'd1;

  typedef enum logic [1:0] {
    GATE_IDLE,
    GATE_WALK,
    GATE_MUL,
    GATE_DECIDE
  } gate_state_t;

  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_LOAD,
    WALK_CMP,
    WALK_DONE
  } walk_state_t;

  typedef struct packed {
    logic              done;
    logic [PEAK_W-1:0] median;
  } walk_status_t;

endpackage

`default_nettype wire

// File: design/ing_stream_if.sv
// Valid/ready channel interfaces for event items and gate results.
// Depends on ing_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ing_in_if;
  logic                        valid;
  logic                        ready;
  logic [ing_pkg::POS_W-1:0]   event_pos;
  logic [ing_pkg::PEAK_W-1:0]  peak_level;
  logic [ing_pkg::KIND_W-1:0]  event_kind;

  modport source (output valid, output event_pos, output peak_level, output event_kind,
                  input ready);
  modport sink   (input valid, input event_pos, input peak_level, input event_kind,
                  output ready);
endinterface

interface ing_out_if;
  logic                        valid;
  logic                        ready;
  logic                        keep;
  logic                        noise;
  logic [ing_pkg::PEAK_W-1:0]  median_peak;

  modport source (output valid, output keep, output noise, output median_peak,
                  input ready);
  modport sink   (input valid, input keep, input noise, input median_peak,
                  output ready);
endinterface

`default_nettype wire

// File: design/ing_window_ram.sv
// Peak window store: one write port, one read port with registered read data.
// Depends on ing_pkg for the peak width.
`timescale 1ns / 1ps
`default_nettype none

module ing_window_ram #(
  parameter int WINDOW = ing_pkg::WINDOW_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(WINDOW)-1:0]  waddr,
  input  wire logic [ing_pkg::PEAK_W-1:0] wdata,
  input  wire logic [$clog2(WINDOW)-1:0]  raddr,
  output logic      [ing_pkg::PEAK_W-1:0] rdata
);

  logic [ing_pkg::PEAK_W-1:0] mem_r [WINDOW];
  logic [ing_pkg::PEAK_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: design/ing_rank_walk.sv
// Rank walk over the held peaks: finds the element of rank count/2 by counting,
// for each candidate, how many held peaks lie below and at or below it.
// Depends on ing_pkg; reads the window through ing_window_ram's read port.
`timescale 1ns / 1ps
`default_nettype none

module ing_rank_walk #(
  parameter int WINDOW = ing_pkg::WINDOW_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [$clog2(WINDOW+1)-1:0]  count,
  output logic      [$clog2(WINDOW)-1:0]    rd_addr,
  input  wire logic [ing_pkg::PEAK_W-1:0]   rd_data,
  output ing_pkg::walk_status_t             status
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);

  ing_pkg::walk_state_t state_r, state_nxt;

  logic [IDX_W-1:0]           i_r, j_r;
  logic [CNT_W-1:0]           n_r, below_r, upto_r;
  logic [ing_pkg::PEAK_W-1:0] cand_r, median_r;

  logic [CNT_W-1:0] below_nxt, upto_nxt, rank;
  logic             last_j, last_i, hit;

  assign below_nxt = below_r + CNT_W'(rd_data < cand_r);
  assign upto_nxt  = upto_r + CNT_W'(rd_data <= cand_r);
  assign rank      = n_r >> 1;
  assign last_j    = (CNT_W'(j_r) == n_r - CNT_W'(1));
  assign last_i    = (CNT_W'(i_r) == n_r - CNT_W'(1));
  assign hit       = (below_nxt <= rank) && (rank < upto_nxt);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ing_pkg::WALK_IDLE: if (start) state_nxt = ing_pkg::WALK_LOAD;
      ing_pkg::WALK_LOAD: state_nxt = ing_pkg::WALK_CMP;
      ing_pkg::WALK_CMP: begin
        if (last_j) begin
          state_nxt = (hit || last_i) ? ing_pkg::WALK_DONE : ing_pkg::WALK_LOAD;
        end
      end
      ing_pkg::WALK_DONE: state_nxt = ing_pkg::WALK_IDLE;
      default: state_nxt = ing_pkg::WALK_IDLE;
    endcase
  end

  always_comb begin
    rd_addr     = '0;
    status.done = 1'b0;
    unique case (state_r)
      ing_pkg::WALK_IDLE: rd_addr = '0;
      ing_pkg::WALK_LOAD: rd_addr = '0;
      ing_pkg::WALK_CMP: begin
        // Next read is the following comparand, or the next candidate.
        rd_addr = last_j ? (i_r + IDX_W'(1)) : (j_r + IDX_W'(1));
      end
      ing_pkg::WALK_DONE: status.done = 1'b1;
      default: rd_addr = '0;
    endcase
    status.median = median_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ing_pkg::WALK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ing_pkg::WALK_IDLE: begin
        i_r <= '0;
        n_r <= count;
      end
      ing_pkg::WALK_LOAD: begin
        cand_r  <= rd_data;
        j_r     <= '0;
        below_r <= '0;
        upto_r  <= '0;
      end
      ing_pkg::WALK_CMP: begin
        below_r <= below_nxt;
        upto_r  <= upto_nxt;
        j_r     <= j_r + IDX_W'(1);
        if (last_j) begin
          i_r <= i_r + IDX_W'(1);
          if (hit) begin
            median_r <= cand_r;
          end else if (last_i) begin
            median_r <= '0;
          end
        end
      end
      ing_pkg::WALK_DONE: begin
        i_r <= '0;
      end
      default: begin
        i_r <= '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/impulse_noise_gate_top.sv
// Impulse noise gate top level: configuration registers, gate sequencer,
// refractory and outlier tests, window update and the result register.
// Depends on ing_pkg, ing_stream_if, ing_window_ram and ing_rank_walk.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake          Contents
// in_ch    sink       valid / ready      event_pos, peak_level, event_kind
// out_ch   source     valid / ready      keep, noise, median_peak
// cfg_*    write      cfg_we, no ready   cfg_index, cfg_wdata
//
// One event is in work at a time. Without an outlier test an event goes from
// capture straight to the decide state; with held peaks the rank walk reads
// candidates and comparands over the single window read port, followed by
// the multiply and decide states. Reset clears the fill count, the oldest slot,
// the position reference and the result valid flag; the window store itself is
// not cleared since only filled slots are ever read. A stalled result holds in
// the output register while the next event is already taken in.

module impulse_noise_gate_top #(
  parameter int WINDOW = ing_pkg::WINDOW_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ing_in_if.sink                              in_ch,
  ing_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [ing_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ing_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int CMP_W = (CNT_W > ing_pkg::MINC_W) ? CNT_W : ing_pkg::MINC_W;

  // Configuration registers.
  logic [ing_pkg::REFR_W-1:0] refr_r;
  logic [ing_pkg::AMPK_W-1:0] ampk_r;
  logic [ing_pkg::MINC_W-1:0] minc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refr_r <= ing_pkg::REFR_RESET;
      ampk_r <= ing_pkg::AMPK_RESET;
      minc_r <= ing_pkg::MINC_RESET;
    end else if (cfg_we) begin
      priority case (cfg_index)
        ing_pkg::CFG_REFRACTORY: refr_r <= cfg_wdata;
        ing_pkg::CFG_AMP_K:      ampk_r <= cfg_wdata[ing_pkg::AMPK_W-1:0];
        ing_pkg::CFG_MIN_COUNT:  minc_r <= cfg_wdata[ing_pkg::MINC_W-1:0];
        default: ;
      endcase
    end
  end

  // Window bookkeeping and the position reference of the last clean event.
  logic [CNT_W-1:0]          count_r;
  logic [IDX_W-1:0]          oldest_r;
  logic [ing_pkg::POS_W-1:0] last_pos_r;
  logic                      last_valid_r;

  // Event held while it is in work.
  logic [ing_pkg::POS_W-1:0]  pos_r;
  logic [ing_pkg::PEAK_W-1:0] peak_r;
  logic [ing_pkg::KIND_W-1:0] kind_r;
  logic                       refr_hit_r;
  logic [ing_pkg::PEAK_W-1:0] median_r;
  logic [ing_pkg::PROD_W-1:0] prod_r;

  // Result register.
  logic                       out_valid_r;
  logic                       keep_r, noise_r;
  logic [ing_pkg::PEAK_W-1:0] median_out_r;

  ing_pkg::gate_state_t state_r, state_nxt;

  logic in_xfer, need_median, commit, noise_w, keep_w, full;
  logic [ing_pkg::POS_W:0] pos_diff;
  logic                    refr_hit;
  logic [IDX_W-1:0]        wr_slot;

  ing_pkg::walk_status_t     walk_status;
  logic                      walk_start;
  logic [IDX_W-1:0]          rd_addr;
  logic [ing_pkg::PEAK_W-1:0] rd_data;

  assign in_xfer = in_ch.valid && in_ch.ready;

  // The outlier test needs at least one held peak and min_count of them.
  assign need_median = (count_r != '0) && (CMP_W'(count_r) >= CMP_W'(minc_r));

  // Refractory test on the exact difference: no borrow means the event is not
  // before the reference, then the low bits are the distance.
  assign pos_diff = {1'b0, in_ch.event_pos} - {1'b0, last_pos_r};
  assign refr_hit = last_valid_r && !pos_diff[ing_pkg::POS_W] &&
                    (pos_diff[ing_pkg::POS_W-1:0] < ing_pkg::POS_W'(refr_r));

  // Outlier test compares peak*256 against median*K, only for a nonzero median.
  assign noise_w = refr_hit_r ||
                   ((median_r != '0) &&
                    (ing_pkg::PROD_W'({peak_r, 8'h00}) > prod_r));

  always_comb begin
    unique case (kind_r)
      ing_pkg::KIND_A: keep_w = 1'b1;
      ing_pkg::KIND_C: keep_w = !noise_w;
      default:         keep_w = 1'b0;
    endcase
  end

  // Once the window is full the oldest peak is overwritten in place.
  assign full    = (count_r >= CNT_W'(WINDOW));
  assign wr_slot = full ? oldest_r : count_r[IDX_W-1:0];

  // Next state of the gate sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ing_pkg::GATE_IDLE: begin
        if (in_xfer) begin
          state_nxt = need_median ? ing_pkg::GATE_WALK : ing_pkg::GATE_DECIDE;
        end
      end
      ing_pkg::GATE_WALK:   if (walk_status.done) state_nxt = ing_pkg::GATE_MUL;
      ing_pkg::GATE_MUL:    state_nxt = ing_pkg::GATE_DECIDE;
      ing_pkg::GATE_DECIDE: if (commit) state_nxt = ing_pkg::GATE_IDLE;
      default:              state_nxt = ing_pkg::GATE_IDLE;
    endcase
  end

  // Sequencer outputs. The decision waits until the result register is free
  // or is emptied in the same cycle.
  always_comb begin
    in_ch.ready = 1'b0;
    walk_start  = 1'b0;
    commit      = 1'b0;
    unique case (state_r)
      ing_pkg::GATE_IDLE: begin
        in_ch.ready = 1'b1;
        walk_start  = in_ch.valid && need_median;
      end
      ing_pkg::GATE_WALK: ;
      ing_pkg::GATE_MUL:  ;
      ing_pkg::GATE_DECIDE: commit = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ing_pkg::GATE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Event capture and datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pos_r      <= in_ch.event_pos;
      peak_r     <= in_ch.peak_level;
      kind_r     <= in_ch.event_kind;
      refr_hit_r <= refr_hit;
      median_r   <= '0;
    end else if (state_r == ing_pkg::GATE_WALK && walk_status.done) begin
      median_r <= walk_status.median;
    end
    if (state_r == ing_pkg::GATE_MUL) begin
      prod_r <= ing_pkg::PROD_W'(median_r) * ing_pkg::PROD_W'(ampk_r);
    end
  end

  // A clean event moves the reference and enters the window. Reads and writes
  // of the window never overlap: the write happens only after the walk is over.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      oldest_r     <= '0;
      last_pos_r   <= '0;
      last_valid_r <= 1'b0;
    end else if (commit && !noise_w) begin
      last_pos_r   <= pos_r;
      last_valid_r <= 1'b1;
      if (!full) begin
        count_r <= count_r + CNT_W'(1);
      end else begin
        oldest_r <= (oldest_r == IDX_W'(WINDOW - 1)) ? '0 : oldest_r + IDX_W'(1);
      end
    end
  end

  // Result register: loads on a decision, empties on an output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      keep_r       <= keep_w;
      noise_r      <= noise_w;
      median_out_r <= median_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.keep        = keep_r;
  assign out_ch.noise       = noise_r;
  assign out_ch.median_peak = median_out_r;

  ing_window_ram #(
    .WINDOW (WINDOW)
  ) u_window_ram (
    .clk   (clk),
    .we    (commit && !noise_w),
    .waddr (wr_slot),
    .wdata (peak_r),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ing_rank_walk #(
    .WINDOW (WINDOW)
  ) u_rank_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (walk_start),
    .count   (count_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .status  (walk_status)
  );

endmodule

`default_nettype wire
